>>> hdl/sle_pkg.sv
// sequential list engine: shared constants, types and codes
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 7;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (IDX_W + 2 > POS_W + 1) ? IDX_W + 2 : POS_W + 1;

  // first-hit search runs over groups of cells, then over groups
  localparam int GROUP    = 8;
  localparam int G_W      = $clog2(GROUP);
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [DATA_W-1:0] GET_FAIL_VALUE = DATA_W'(9999);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_t;

  typedef struct packed {
    logic              capture;
    logic              ins;
    logic              del;
    logic              sel;
    logic              loc;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [G_W-1:0]    idx;
    logic [DATA_W-1:0] data;
  } pick_t;

endpackage

>>> hdl/sle_in_if.sv
// request channel: action, position and value words
interface sle_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [sle_pkg::POS_W-1:0]       position;
  logic signed [sle_pkg::DATA_W-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

>>> hdl/sle_out_if.sv
// result channel: status, data, match position and list count
interface sle_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [sle_pkg::DATA_W-1:0] data_out;
  logic [sle_pkg::POS_W-1:0]         found_position;
  logic [sle_pkg::COUNT_W-1:0]       count;

  modport source (output valid, ok, data_out, found_position, count, input ready);
  modport sink   (input valid, ok, data_out, found_position, count, output ready);
endinterface

>>> hdl/sle_cell.sv
// one list slot: shifts with its neighbours and flags a position or value hit
module sle_cell (
  input  logic                        clk,
  input  sle_pkg::cell_ctrl_t         ctrl,
  input  logic [sle_pkg::IDX_W-1:0]   index,
  input  logic [sle_pkg::DATA_W-1:0]  left,
  input  logic [sle_pkg::DATA_W-1:0]  right,
  output logic [sle_pkg::DATA_W-1:0]  data,
  output logic                        hit,
  output logic [sle_pkg::DATA_W-1:0]  hold
);

  logic [sle_pkg::CMP_W-1:0] slot;
  logic [sle_pkg::CMP_W-1:0] pos_x;
  logic [sle_pkg::CMP_W-1:0] len_x;

  // slot is the 1-based position of this cell
  assign slot  = sle_pkg::CMP_W'(index) + sle_pkg::CMP_W'(1);
  assign pos_x = sle_pkg::CMP_W'(ctrl.pos);
  assign len_x = sle_pkg::CMP_W'(ctrl.len);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (slot == pos_x) begin
        data <= ctrl.value;
      end else if (slot > pos_x) begin
        data <= left;
      end
    end else if (ctrl.del && slot >= pos_x) begin
      data <= right;
    end
    // hold keeps the word as it was before any shift
    if (ctrl.capture) begin
      hold <= data;
      hit  <= (ctrl.sel && slot == pos_x) ||
              (ctrl.loc && slot <= len_x && data == ctrl.value);
    end
  end

endmodule

>>> hdl/sle_pick.sv
// lowest-index hit among one group of flags, with its word
module sle_pick (
  input  logic [sle_pkg::GROUP-1:0]                    hits,
  input  logic [sle_pkg::GROUP-1:0][sle_pkg::DATA_W-1:0] words,
  output sle_pkg::pick_t                               pick
);

  always_comb begin
    pick = '0;
    for (int i = sle_pkg::GROUP - 1; i >= 0; i--) begin
      if (hits[i]) begin
        pick.hit  = 1'b1;
        pick.idx  = sle_pkg::G_W'(i);
        pick.data = words[i];
      end
    end
  end

endmodule

>>> hdl/sequential_list_engine_top.sv
// sequential list engine: ordered list of words in a row of shifting cells
//
// Requests arrive on req (action, 1-based position, value); one result per
// request leaves on rsp (ok, data_out, found_position, count). Insert and
// delete shift the cells at and past the given position by one place in the
// cycle the word is taken; each cell then flags its own hit (position match,
// or value match for locate) and a two-level registered search over groups
// of eight cells picks the first hit.
// A result passes the cell stage, the group-pick stage and the output
// register. A request is taken only when both search stages are empty; the
// next request is taken while a finished result still waits on rsp.
// Reset (rst, synchronous) empties the list and drops any word in flight;
// list contents are not cleared and need not be.
// When the receiver holds rsp.ready low the result stays on rsp, one more
// request may be taken and completes into the search stage, then req.ready
// stays low until the waiting result is taken.
module sequential_list_engine_top (
  input  logic             clk,
  input  logic             rst,
  sle_in_if.sink           req,
  sle_out_if.source        rsp
);

  logic [sle_pkg::LEN_W-1:0]   len;
  logic [sle_pkg::LEN_W-1:0]   len_next;
  logic [sle_pkg::CMP_W-1:0]   pos_x;
  logic [sle_pkg::CMP_W-1:0]   len_x;
  logic                        accept;
  logic                        ins_ok;
  logic                        rd_ok;
  logic                        ok_pre;
  sle_pkg::action_t            act;
  sle_pkg::cell_ctrl_t         ctrl;

  logic [sle_pkg::DATA_W-1:0]  cell_data [sle_pkg::CAPACITY];
  logic [sle_pkg::DATA_W-1:0]  cell_hold [sle_pkg::CAPACITY];
  logic                        cell_hit  [sle_pkg::CAPACITY];

  logic                        s1_v;
  sle_pkg::action_t            s1_act;
  logic                        s1_ok;
  logic [sle_pkg::COUNT_W-1:0] s1_cnt;

  logic                        s2_v;
  sle_pkg::action_t            s2_act;
  logic                        s2_ok;
  logic [sle_pkg::COUNT_W-1:0] s2_cnt;
  sle_pkg::pick_t              s2_pick [sle_pkg::GROUP];

  sle_pkg::pick_t              l1_pick [sle_pkg::GROUP];
  sle_pkg::pick_t              l2_pick;
  logic [sle_pkg::GROUP-1:0]   l2_hits;
  logic [sle_pkg::GROUP-1:0][sle_pkg::DATA_W-1:0] l2_words;
  logic [sle_pkg::G_W-1:0]     lo_idx;
  logic                        s2_move;
  logic                        out_v;

  // request side
  assign act    = sle_pkg::action_t'(req.action);
  assign req.ready = !s1_v && !s2_v;
  assign accept = req.valid && req.ready;
  assign pos_x  = sle_pkg::CMP_W'(req.position);
  assign len_x  = sle_pkg::CMP_W'(len);

  assign ins_ok = (req.position != '0) && (pos_x <= len_x + sle_pkg::CMP_W'(1)) &&
                  (len_x < sle_pkg::CMP_W'(sle_pkg::CAPACITY));
  assign rd_ok  = (req.position != '0) && (pos_x <= len_x);

  always_comb begin
    ctrl         = '0;
    ctrl.capture = accept;
    ctrl.pos     = req.position;
    ctrl.len     = len;
    ctrl.value   = req.value;
    len_next     = len;
    ok_pre       = 1'b0;
    case (act)
      sle_pkg::ACT_INSERT: begin
        ok_pre   = ins_ok;
        ctrl.ins = accept && ins_ok;
        if (ins_ok) len_next = len + sle_pkg::LEN_W'(1);
      end
      sle_pkg::ACT_DELETE: begin
        ok_pre   = rd_ok;
        ctrl.del = accept && rd_ok;
        ctrl.sel = rd_ok;
        if (rd_ok) len_next = len - sle_pkg::LEN_W'(1);
      end
      sle_pkg::ACT_GET: begin
        ok_pre   = rd_ok;
        ctrl.sel = rd_ok;
      end
      sle_pkg::ACT_LOCATE: begin
        ctrl.loc = 1'b1;
      end
      default: begin
        ok_pre = 1'b0;
      end
    endcase
  end

  // row of cells, each fed by its neighbours
  for (genvar k = 0; k < sle_pkg::CAPACITY; k++) begin : g_cell
    logic [sle_pkg::DATA_W-1:0] left_w;
    logic [sle_pkg::DATA_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == sle_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    sle_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .index (sle_pkg::IDX_W'(k)),
      .left  (left_w),
      .right (right_w),
      .data  (cell_data[k]),
      .hit   (cell_hit[k]),
      .hold  (cell_hold[k])
    );
  end

  // first search level: one pick per group of cells
  for (genvar g = 0; g < sle_pkg::GROUP; g++) begin : g_grp
    logic [sle_pkg::GROUP-1:0]                     hits_w;
    logic [sle_pkg::GROUP-1:0][sle_pkg::DATA_W-1:0] words_w;
    for (genvar j = 0; j < sle_pkg::GROUP; j++) begin : g_slot
      if (g * sle_pkg::GROUP + j < sle_pkg::CAPACITY) begin : g_used
        assign hits_w[j]  = cell_hit[g * sle_pkg::GROUP + j];
        assign words_w[j] = cell_hold[g * sle_pkg::GROUP + j];
      end else begin : g_pad
        assign hits_w[j]  = 1'b0;
        assign words_w[j] = '0;
      end
    end
    sle_pick u_pick (
      .hits  (hits_w),
      .words (words_w),
      .pick  (l1_pick[g])
    );
  end

  // second search level over the registered group picks
  always_comb begin
    for (int g = 0; g < sle_pkg::GROUP; g++) begin
      l2_hits[g]  = s2_pick[g].hit;
      l2_words[g] = s2_pick[g].data;
    end
  end

  sle_pick u_pick_top (
    .hits  (l2_hits),
    .words (l2_words),
    .pick  (l2_pick)
  );

  assign lo_idx  = s2_pick[l2_pick.idx].idx;
  assign s2_move = s2_v && (!out_v || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (accept) begin
        len <= len_next;
      end
      s1_v <= accept;
      if (s1_v) begin
        s2_v <= 1'b1;
      end else if (s2_move) begin
        s2_v <= 1'b0;
      end
      if (s2_move) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act <= act;
      s1_ok  <= ok_pre;
      s1_cnt <= sle_pkg::COUNT_W'(len_next);
    end
    if (s1_v) begin
      s2_act <= s1_act;
      s2_ok  <= s1_ok;
      s2_cnt <= s1_cnt;
      for (int g = 0; g < sle_pkg::GROUP; g++) begin
        if (g < sle_pkg::NGROUP) begin
          s2_pick[g] <= l1_pick[g];
        end else begin
          s2_pick[g] <= '0;
        end
      end
    end
    if (s2_move) begin
      rsp.count          <= s2_cnt;
      rsp.found_position <= '0;
      case (s2_act)
        sle_pkg::ACT_INSERT: begin
          rsp.ok       <= s2_ok;
          rsp.data_out <= '0;
        end
        sle_pkg::ACT_DELETE: begin
          rsp.ok       <= s2_ok;
          rsp.data_out <= s2_ok ? l2_pick.data : '0;
        end
        sle_pkg::ACT_GET: begin
          rsp.ok       <= s2_ok;
          rsp.data_out <= s2_ok ? l2_pick.data : sle_pkg::GET_FAIL_VALUE;
        end
        sle_pkg::ACT_LOCATE: begin
          rsp.ok       <= l2_pick.hit;
          rsp.data_out <= '0;
          // match position is group index over slot index, made 1-based
          if (l2_pick.hit) begin
            rsp.found_position <= sle_pkg::POS_W'({l2_pick.idx, lo_idx}) +
                                  sle_pkg::POS_W'(1);
          end
        end
        default: begin
          rsp.ok       <= 1'b0;
          rsp.data_out <= '0;
        end
      endcase
    end
  end

  assign rsp.valid = out_v;

  a_one_in_search: assert property (@(posedge clk) disable iff (rst)
    !(s1_v && s2_v))
    else $error("two words in the search stages at once");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_v)
    else $error("accepted word did not enter the cell stage");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    sle_pkg::CMP_W'(len) <= sle_pkg::CMP_W'(sle_pkg::CAPACITY))
    else $error("list length above capacity");

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_v && out_v && !rsp.ready) |=> s2_v)
    else $error("search result lost while output stalled");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && act == sle_pkg::ACT_INSERT && ins_ok) |=>
      (len == $past(len) + sle_pkg::LEN_W'(1)))
    else $error("insert did not grow the list");

endmodule
